### rtl/core/bmx_pkg.sv
// Shared types and constants for the binary trie max-xor multiset block.
// Used by bmx_node_ram, bmx_engine and binary_trie_max_xor_multiset_top.
`default_nettype none

package bmx_pkg;

   localparam int KEY_BITS_DEF   = 31;
   localparam int NODE_COUNT_DEF = 65536;

   // field widths fixed by the stream format
   localparam int OP_BITS     = 2;
   localparam int KEY_IN_BITS = 31;
   localparam int RESULT_BITS = 31;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = 30;

   localparam int REQ_TDATA_BITS = 40;
   localparam int RSP_TDATA_BITS = 40;
   localparam int REQ_PAD_BITS   = REQ_TDATA_BITS - OP_BITS - KEY_IN_BITS;
   localparam int RSP_PAD_BITS   = RSP_TDATA_BITS - RESULT_BITS - STATUS_BITS;

   localparam int NULL_NODE = 0;
   localparam int ROOT_NODE = 1;
   localparam int FIRST_FREE_NODE = 2;

   localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_BITS-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_QUERY  = 2'd2;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_DONE      = 2'd0,
      ST_POOL_FULL = 2'd1,
      ST_ABSENT    = 2'd2
   } status_type;

   typedef struct packed {
      logic [RESULT_BITS-1:0] result_value;
      status_type             status;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/core/bmx_node_ram.sv
// Trie node memory: one write port, one registered read port.
// Node 0 and a never-written root read as all zeros; uses bmx_pkg.
`default_nettype none

module bmx_node_ram #(
   parameter int DEPTH     = bmx_pkg::NODE_COUNT_DEF,
   parameter int ADDR_BITS = $clog2(bmx_pkg::NODE_COUNT_DEF),
   parameter int DATA_BITS = 2 * $clog2(bmx_pkg::NODE_COUNT_DEF) + bmx_pkg::COUNT_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] node_mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_q_ff;
   logic                 zero_q_ff;
   logic                 zero_q_in;
   logic                 root_ok_ff;
   logic                 root_ok_in;

   always_comb begin
      zero_q_in = (rd_addr == ADDR_BITS'(bmx_pkg::NULL_NODE)) ||
                  ((rd_addr == ADDR_BITS'(bmx_pkg::ROOT_NODE)) && !root_ok_ff);
      root_ok_in = root_ok_ff || (wr_en && (wr_addr == ADDR_BITS'(bmx_pkg::ROOT_NODE)));
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem_ff[wr_addr] <= wr_data;
      end
      rd_q_ff   <= node_mem_ff[rd_addr];
      zero_q_ff <= zero_q_in;
   end

   // root stands in for the reset clear of node 1
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ok_ff <= 1'b0;
      end else begin
         root_ok_ff <= root_ok_in;
      end
   end

   assign rd_data = zero_q_ff ? '0 : rd_q_ff;

endmodule

`default_nettype wire

### rtl/core/bmx_engine.sv
// Sequencer for trie insert, delete and max-xor query, one node visit at a time.
// Drives bmx_node_ram; shares one count adder; uses bmx_pkg.
`default_nettype none

module bmx_engine #(
   parameter int KEY_BITS   = bmx_pkg::KEY_BITS_DEF,
   parameter int NODE_COUNT = bmx_pkg::NODE_COUNT_DEF,
   parameter int NB         = $clog2(bmx_pkg::NODE_COUNT_DEF),
   parameter int NW         = 2 * $clog2(bmx_pkg::NODE_COUNT_DEF) + bmx_pkg::COUNT_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [bmx_pkg::OP_BITS-1:0]         req_opcode,
   input  wire logic [bmx_pkg::KEY_IN_BITS-1:0]     req_key,
   output logic                                     done_valid,
   input  wire logic                                done_ready,
   output bmx_pkg::rsp_type                         done_word,
   output logic                                     ram_wr_en,
   output logic      [NB-1:0]                       ram_wr_addr,
   output logic      [NW-1:0]                       ram_wr_data,
   output logic      [NB-1:0]                       ram_rd_addr,
   input  wire logic [NW-1:0]                       ram_rd_data
);

   localparam int CB = bmx_pkg::COUNT_BITS;
   localparam int RB = bmx_pkg::RESULT_BITS;
   localparam int KI = bmx_pkg::KEY_IN_BITS;
   localparam int LB = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
   localparam int FB = NB + 1;
   localparam logic [FB-1:0] FREE_LIMIT = FB'(NODE_COUNT - KEY_BITS);

   localparam logic [1:0] QPH_NODE  = 2'd0;
   localparam logic [1:0] QPH_WANT  = 2'd1;
   localparam logic [1:0] QPH_OTHER = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RD,
      S_EV,
      S_DONE
   } state_type;

   state_type                     state_ff, state_in;
   logic [bmx_pkg::OP_BITS-1:0]   op_ff, op_in;
   logic [KEY_BITS-1:0]           key_ff, key_in;
   logic [NB-1:0]                 idx_ff, idx_in;
   logic [LB-1:0]                 lvl_ff, lvl_in;
   logic                          leaf_ff, leaf_in;
   logic                          fresh_ff, fresh_in;
   logic                          pass_ff, pass_in;
   logic [1:0]                    qph_ff, qph_in;
   logic [KEY_BITS-1:0]           best_ff, best_in;
   logic [NB-1:0]                 cur0_ff, cur0_in;
   logic [NB-1:0]                 cur1_ff, cur1_in;
   logic [FB-1:0]                 next_free_ff, next_free_in;
   bmx_pkg::rsp_type              rsp_ff, rsp_in;

   logic [NW-1:0]       nd;
   logic [CB-1:0]       nd_count;
   logic [NB-1:0]       nd_link0;
   logic [NB-1:0]       nd_link1;
   logic [CB-1:0]       cnt_step;
   logic [CB-1:0]       cnt_sum;
   logic [CB-1:0]       cnt_new;
   logic [LB-1:0]       lvl_dn;
   logic                bit_cur;
   logic                bit_dn;
   logic [NB-1:0]       targ;
   logic                need_alloc;
   logic [NB-1:0]       new_link;
   logic [KEY_BITS-1:0] best_nx;
   logic                hit;
   logic [KEY_BITS+KI-1:0] key_wide;
   logic [KEY_BITS+RB-1:0] best_wide;
   logic [KEY_BITS+RB-1:0] keyr_wide;

   always_comb begin
      nd       = fresh_ff ? '0 : ram_rd_data;
      nd_count = nd[CB-1:0];
      nd_link0 = nd[CB+NB-1:CB];
      nd_link1 = nd[NW-1:CB+NB];

      // shared count unit: +1 saturating for insert, -1 for delete
      cnt_step = (op_ff == bmx_pkg::OP_DELETE) ? {CB{1'b1}} : CB'(1);
      cnt_sum  = nd_count + cnt_step;
      cnt_new  = ((op_ff == bmx_pkg::OP_INSERT) && (nd_count == {CB{1'b1}})) ?
                 nd_count : cnt_sum;

      lvl_dn  = lvl_ff - 1'b1;
      bit_cur = key_ff[lvl_ff];
      bit_dn  = key_ff[lvl_dn];
      targ    = bit_cur ? nd_link1 : nd_link0;
      need_alloc = (op_ff == bmx_pkg::OP_INSERT) && !leaf_ff &&
                   (targ == NB'(bmx_pkg::NULL_NODE));
      new_link = need_alloc ? next_free_ff[NB-1:0] : targ;

      hit     = (nd_count != '0);
      best_nx = (best_ff << 1) | KEY_BITS'(hit);

      key_wide  = {{KEY_BITS{1'b0}}, req_key};
      best_wide = {{RB{1'b0}}, best_nx};
      keyr_wide = {{RB{1'b0}}, key_ff};

      ram_wr_addr = idx_ff;
      ram_rd_addr = idx_ff;
      ram_wr_data = {((!leaf_ff && bit_cur) ? new_link : nd_link1),
                     ((!leaf_ff && !bit_cur) ? new_link : nd_link0),
                     cnt_new};
      ram_wr_en = 1'b0;

      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      lvl_in       = lvl_ff;
      leaf_in      = leaf_ff;
      fresh_in     = fresh_ff;
      pass_in      = pass_ff;
      qph_in       = qph_ff;
      best_in      = best_ff;
      cur0_in      = cur0_ff;
      cur1_in      = cur1_ff;
      next_free_in = next_free_ff;
      rsp_in       = rsp_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               key_in   = key_wide[KEY_BITS-1:0];
               idx_in   = NB'(bmx_pkg::ROOT_NODE);
               lvl_in   = LB'(KEY_BITS - 1);
               leaf_in  = 1'b0;
               fresh_in = 1'b0;
               pass_in  = 1'b0;
               qph_in   = QPH_NODE;
               best_in  = '0;
               rsp_in.result_value = '0;
               rsp_in.status       = bmx_pkg::ST_DONE;
               if (req_opcode == bmx_pkg::OP_INSERT) begin
                  if (next_free_ff > FREE_LIMIT) begin
                     rsp_in.status = bmx_pkg::ST_POOL_FULL;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_RD;
                  end
               end else if ((req_opcode == bmx_pkg::OP_DELETE) ||
                            (req_opcode == bmx_pkg::OP_QUERY)) begin
                  state_in = S_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end

         S_RD: begin
            state_in = S_EV;
         end

         S_EV: begin
            state_in = S_RD;
            if (op_ff == bmx_pkg::OP_INSERT) begin
               ram_wr_en = 1'b1;
               fresh_in  = need_alloc;
               idx_in    = new_link;
               if (need_alloc) begin
                  next_free_in = next_free_ff + 1'b1;
               end
               if (leaf_ff) begin
                  state_in = S_DONE;
               end else if (lvl_ff == '0) begin
                  leaf_in = 1'b1;
               end else begin
                  lvl_in = lvl_dn;
               end
            end else if (op_ff == bmx_pkg::OP_DELETE) begin
               idx_in = targ;
               if (!pass_ff && !hit) begin
                  rsp_in.status = bmx_pkg::ST_ABSENT;
                  state_in      = S_DONE;
               end else if (!pass_ff && leaf_ff) begin
                  // key is present: rewalk and lower the counts
                  pass_in = 1'b1;
                  idx_in  = NB'(bmx_pkg::ROOT_NODE);
                  lvl_in  = LB'(KEY_BITS - 1);
                  leaf_in = 1'b0;
               end else begin
                  ram_wr_en = pass_ff;
                  if (leaf_ff) begin
                     state_in = S_DONE;
                  end else if (lvl_ff == '0) begin
                     leaf_in = 1'b1;
                  end else begin
                     lvl_in = lvl_dn;
                  end
               end
            end else begin
               case (qph_ff)
                  QPH_NODE: begin
                     if (!hit) begin
                        rsp_in.result_value = keyr_wide[RB-1:0];
                        state_in            = S_DONE;
                     end else begin
                        cur0_in = nd_link0;
                        cur1_in = nd_link1;
                        idx_in  = bit_cur ? nd_link0 : nd_link1;
                        qph_in  = QPH_WANT;
                     end
                  end
                  QPH_WANT: begin
                     if (!hit) begin
                        // wanted branch empty: take the other one
                        idx_in = bit_cur ? cur1_ff : cur0_ff;
                        qph_in = QPH_OTHER;
                     end else begin
                        best_in = best_nx;
                        if (lvl_ff == '0) begin
                           rsp_in.result_value = best_wide[RB-1:0];
                           state_in            = S_DONE;
                        end else begin
                           cur0_in = nd_link0;
                           cur1_in = nd_link1;
                           lvl_in  = lvl_dn;
                           idx_in  = bit_dn ? nd_link0 : nd_link1;
                        end
                     end
                  end
                  default: begin
                     // other branch: bit is zero
                     best_in = best_ff << 1;
                     cur0_in = nd_link0;
                     cur1_in = nd_link1;
                     qph_in  = QPH_WANT;
                     if (lvl_ff == '0) begin
                        best_wide           = {{RB{1'b0}}, best_ff << 1};
                        rsp_in.result_value = best_wide[RB-1:0];
                        state_in            = S_DONE;
                     end else begin
                        lvl_in = lvl_dn;
                        idx_in = bit_dn ? nd_link0 : nd_link1;
                     end
                  end
               endcase
            end
         end

         S_DONE: begin
            if (done_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         next_free_ff <= FB'(bmx_pkg::FIRST_FREE_NODE);
         fresh_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_free_ff <= next_free_in;
         fresh_ff     <= fresh_in;
      end
      op_ff   <= op_in;
      key_ff  <= key_in;
      idx_ff  <= idx_in;
      lvl_ff  <= lvl_in;
      leaf_ff <= leaf_in;
      pass_ff <= pass_in;
      qph_ff  <= qph_in;
      best_ff <= best_in;
      cur0_ff <= cur0_in;
      cur1_ff <= cur1_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign done_valid = (state_ff == S_DONE);
   assign done_word  = rsp_ff;

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= FB'(NODE_COUNT))
      else $error("node allocation ran past the pool");

   a_no_null_write: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (ram_wr_addr != NB'(bmx_pkg::NULL_NODE)))
      else $error("write to the null node");

   a_alloc_in_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_EV) |=> $stable(next_free_ff))
      else $error("free pointer moved outside a node update");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !done_ready) |=> (state_ff == S_DONE && $stable(rsp_ff)))
      else $error("finished word dropped before it was taken");

endmodule

`default_nettype wire

### rtl/core/binary_trie_max_xor_multiset_top.sv
// Top level of the binary trie max-xor multiset: stream ports and result register.
// Instantiates bmx_node_ram and bmx_engine; uses bmx_pkg.
`default_nettype none

// Keeps a multiset of KEY_BITS-bit keys in a binary trie of NODE_COUNT nodes
// held in one memory with one write port and a registered read. Opcode 0 inserts a
// key, 1 deletes one copy, 2 returns the largest xor of the key with any
// stored key (the key itself when the set is empty); opcode 3 does nothing.
// Every word in gives exactly one word out. Each node visit is a read and an
// evaluate/write on the node memory, one key bit per visit. A delete makes a
// membership walk, then a walk that lowers the counts; a query visits more
// nodes the more often the preferred branch is empty. A query on an empty set
// stops at the root, a refused delete ends at the first node with a zero
// count, and refused inserts and opcode 3 visit no node. No word is taken
// while one is in progress; a finished result waits in the output register
// while the next word is accepted. An insert is refused (status 1) when
// fewer than KEY_BITS nodes remain free, a delete of an absent key is
// refused (status 2).
// The node memory needs no clearing pass after reset.
module binary_trie_max_xor_multiset_top #(
   parameter int KEY_BITS   = bmx_pkg::KEY_BITS_DEF,
   parameter int NODE_COUNT = bmx_pkg::NODE_COUNT_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // [1:0] opcode, [32:2] key_value, rest zero
   input  wire logic [bmx_pkg::REQ_TDATA_BITS-1:0]    req_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // [30:0] result_value, [32:31] status, rest zero
   output logic      [bmx_pkg::RSP_TDATA_BITS-1:0]    rsp_tdata
);

   localparam int NB = $clog2(NODE_COUNT);
   localparam int NW = 2 * NB + bmx_pkg::COUNT_BITS;
   localparam int OB = bmx_pkg::OP_BITS;
   localparam int KI = bmx_pkg::KEY_IN_BITS;

   logic             ram_wr_en;
   logic [NB-1:0]    ram_wr_addr;
   logic [NW-1:0]    ram_wr_data;
   logic [NB-1:0]    ram_rd_addr;
   logic [NW-1:0]    ram_rd_data;
   logic             done_valid;
   logic             done_ready;
   bmx_pkg::rsp_type done_word;

   logic             rsp_valid_ff, rsp_valid_in;
   bmx_pkg::rsp_type rsp_word_ff, rsp_word_in;

   bmx_node_ram #(
      .DEPTH     (NODE_COUNT),
      .ADDR_BITS (NB),
      .DATA_BITS (NW)
   ) u_node_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bmx_engine #(
      .KEY_BITS   (KEY_BITS),
      .NODE_COUNT (NODE_COUNT),
      .NB         (NB),
      .NW         (NW)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_opcode  (req_tdata[OB-1:0]),
      .req_key     (req_tdata[OB+KI-1:OB]),
      .done_valid  (done_valid),
      .done_ready  (done_ready),
      .done_word   (done_word),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // output register: load when empty or draining this cycle
   always_comb begin
      done_ready   = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_word_in  = rsp_word_ff;
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = done_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{bmx_pkg::RSP_PAD_BITS{1'b0}}, rsp_word_ff.status,
                        rsp_word_ff.result_value};

endmodule

`default_nettype wire

### tb/tb_binary_trie_max_xor_multiset_top.sv
// Self-checking bench for binary_trie_max_xor_multiset_top: directed table, then a
// random mix; every result is checked against a fixed value or a local trie model.
// Depends on bmx_pkg and the RTL under rtl/core.
module tb_binary_trie_max_xor_multiset_top;
   import bmx_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int KEY_BITS       = KEY_BITS_DEF;
   localparam int NODE_COUNT     = NODE_COUNT_DEF;
   localparam int RANDOM_WORDS   = 690;
   localparam int SQUEEZE_CYCLES = 600;
   localparam int DRAIN_CYCLES   = 4 * KEY_BITS + 40;
   localparam int CYCLE_LIMIT    = 10_000_000;
   localparam int HITS_MAX       = (1 << COUNT_BITS) - 1;

   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
   localparam logic [KEY_IN_BITS-1:0] KEY_MASK = (KEY_BITS >= KEY_IN_BITS) ? '1 :
      KEY_IN_BITS'((64'd1 << KEY_BITS) - 1);

   typedef struct packed {
      logic [OP_BITS-1:0]     op;
      logic [KEY_IN_BITS-1:0] key;
      bit                     fixed;
      rsp_type                want;
   } dir_row_type;

   // fixed rows carry their result; the others are predicted
   localparam dir_row_type DIR_ROWS [24] = '{
      '{OP_QUERY,  31'h0000_0000, 1'b1, '{31'h0000_0000, ST_DONE}},
      '{OP_QUERY,  31'h7FFF_FFFF, 1'b1, '{31'h7FFF_FFFF, ST_DONE}},
      '{OP_DELETE, 31'h0001_2345, 1'b1, '{31'h0000_0000, ST_ABSENT}},
      '{OP_UNUSED, 31'h5555_5555, 1'b1, '{31'h0000_0000, ST_DONE}},
      '{OP_INSERT, 31'h0000_0000, 1'b1, '{31'h0000_0000, ST_DONE}},
      '{OP_QUERY,  31'h7FFF_FFFF, 1'b1, '{31'h7FFF_FFFF, ST_DONE}},
      '{OP_INSERT, 31'h7FFF_FFFF, 1'b1, '{31'h0000_0000, ST_DONE}},
      '{OP_QUERY,  31'h0000_0000, 1'b1, '{31'h7FFF_FFFF, ST_DONE}},
      '{OP_QUERY,  31'h2AAA_AAAA, 1'b1, '{31'h5555_5555, ST_DONE}},
      '{OP_DELETE, 31'h0000_0000, 1'b1, '{31'h0000_0000, ST_DONE}},
      '{OP_DELETE, 31'h0000_0000, 1'b1, '{31'h0000_0000, ST_ABSENT}},
      '{OP_QUERY,  31'h7FFF_FFFF, 1'b1, '{31'h0000_0000, ST_DONE}},
      '{OP_INSERT, 31'h7FFF_FFFF, 1'b1, '{31'h0000_0000, ST_DONE}},
      '{OP_DELETE, 31'h7FFF_FFFF, 1'b1, '{31'h0000_0000, ST_DONE}},
      '{OP_QUERY,  31'h0000_0005, 1'b0, '{31'h0000_0000, ST_DONE}},
      '{OP_DELETE, 31'h7FFF_FFFF, 1'b1, '{31'h0000_0000, ST_DONE}},
      '{OP_QUERY,  31'h0123_4567, 1'b1, '{31'h0123_4567, ST_DONE}},
      '{OP_DELETE, 31'h7FFF_FFFE, 1'b1, '{31'h0000_0000, ST_ABSENT}},
      '{OP_INSERT, 31'h4000_0000, 1'b1, '{31'h0000_0000, ST_DONE}},
      '{OP_INSERT, 31'h3FFF_FFFF, 1'b1, '{31'h0000_0000, ST_DONE}},
      '{OP_QUERY,  31'h4000_0000, 1'b0, '{31'h0000_0000, ST_DONE}},
      '{OP_DELETE, 31'h4000_0001, 1'b1, '{31'h0000_0000, ST_ABSENT}},
      '{OP_UNUSED, 31'h7FFF_FFFF, 1'b1, '{31'h0000_0000, ST_DONE}},
      '{OP_QUERY,  31'h1555_5555, 1'b0, '{31'h0000_0000, ST_DONE}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;

   binary_trie_max_xor_multiset_top #(
      .KEY_BITS   (KEY_BITS),
      .NODE_COUNT (NODE_COUNT)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // local copy of the trie
   int child [NODE_COUNT][2];
   int hits [NODE_COUNT];
   int alloc_ptr;

   rsp_type pending_results[$];
   logic [KEY_IN_BITS-1:0] live_keys[$];
   bit quiet_stretch = 1'b0;
   int mismatches = 0;
   int words_checked = 0;
   int n_ins = 0, n_full = 0, n_del = 0, n_absent = 0, n_qry = 0, n_unused = 0;

   function automatic bit trie_holds(input logic [KEY_IN_BITS-1:0] key);
      int at;
      int lvl;
      at = ROOT_NODE;
      for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
         if (hits[at] == 0) return 1'b0;
         at = child[at][key[lvl]];
      end
      return hits[at] != 0;
   endfunction

   function automatic status_type trie_insert(input logic [KEY_IN_BITS-1:0] key);
      int at;
      int lvl;
      at = ROOT_NODE;
      if (NODE_COUNT - alloc_ptr < KEY_BITS) return ST_POOL_FULL;
      for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
         if (hits[at] < HITS_MAX) hits[at]++;
         if (child[at][key[lvl]] == NULL_NODE) begin
            child[alloc_ptr][0] = NULL_NODE;
            child[alloc_ptr][1] = NULL_NODE;
            hits[alloc_ptr] = 0;
            child[at][key[lvl]] = alloc_ptr;
            alloc_ptr++;
         end
         at = child[at][key[lvl]];
      end
      if (hits[at] < HITS_MAX) hits[at]++;
      return ST_DONE;
   endfunction

   function automatic status_type trie_delete(input logic [KEY_IN_BITS-1:0] key);
      int at;
      int lvl;
      at = ROOT_NODE;
      if (!trie_holds(key)) return ST_ABSENT;
      for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
         hits[at]--;
         at = child[at][key[lvl]];
      end
      hits[at]--;
      return ST_DONE;
   endfunction

   function automatic logic [RESULT_BITS-1:0] trie_best_xor(
      input logic [KEY_IN_BITS-1:0] key);
      int at;
      int nxt;
      int lvl;
      logic [RESULT_BITS-1:0] best;
      at = ROOT_NODE;
      best = '0;
      if (hits[ROOT_NODE] == 0) return key;
      for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
         nxt = child[at][!key[lvl]];
         best = best << 1;
         if (hits[nxt] > 0) best[0] = 1'b1;
         else nxt = child[at][key[lvl]];
         at = nxt;
      end
      return best;
   endfunction

   function automatic rsp_type trie_step(input logic [OP_BITS-1:0] op,
                                         input logic [KEY_IN_BITS-1:0] key);
      rsp_type r;
      r.result_value = '0;
      r.status = ST_DONE;
      case (op)
         OP_INSERT: r.status = trie_insert(key);
         OP_DELETE: r.status = trie_delete(key);
         OP_QUERY:  r.result_value = trie_best_xor(key);
         default: ;
      endcase
      return r;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 10);
      return $urandom_range(20, 100);
   endfunction

   function automatic int pick_gap();
      if (quiet_stretch || $urandom_range(0, 99) < 50) return 0;
      return idle_len();
   endfunction

   // mostly random keys, some near or equal to stored ones, some at the edges
   function automatic logic [KEY_IN_BITS-1:0] pick_key();
      int r;
      logic [KEY_IN_BITS-1:0] k;
      r = $urandom_range(0, 99);
      k = KEY_IN_BITS'($urandom());
      if (live_keys.size() != 0 && r >= 55 && r < 85) begin
         k = live_keys[$urandom_range(0, live_keys.size() - 1)];
         if (r < 75) k[$urandom_range(0, KEY_BITS - 1)] ^= 1'b1;
      end else if (r >= 85 && r < 92) begin
         k = KEY_IN_BITS'($urandom_range(0, 15));
      end else if (r >= 92) begin
         k = KEY_MASK ^ KEY_IN_BITS'($urandom_range(0, 15));
      end
      return k;
   endfunction

   task automatic send_word(input logic [OP_BITS-1:0] op, input logic [KEY_IN_BITS-1:0] key,
                            input bit fixed, input rsp_type want);
      int gap;
      int idx[$];
      rsp_type model_rsp;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {{REQ_PAD_BITS{1'b0}}, key, op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      model_rsp = trie_step(op, key & KEY_MASK);
      case (op)
         OP_INSERT: begin
            n_ins++;
            if (model_rsp.status == ST_POOL_FULL) n_full++;
            else live_keys = {live_keys, key & KEY_MASK};
         end
         OP_DELETE: begin
            n_del++;
            if (model_rsp.status == ST_ABSENT) begin
               n_absent++;
            end else begin
               idx = live_keys.find_first_index(x) with (x == (key & KEY_MASK));
               if (idx.size() != 0) live_keys.delete(idx[0]);
            end
         end
         OP_QUERY: n_qry++;
         default: n_unused++;
      endcase
      pending_results = {pending_results, (fixed ? want : model_rsp)};
   endtask

   task automatic send_random(input int ins_pct, input int del_pct, input int qry_pct);
      int r;
      logic [OP_BITS-1:0] op;
      logic [KEY_IN_BITS-1:0] key;
      r = $urandom_range(0, 99);
      key = pick_key();
      if (r < ins_pct) begin
         op = OP_INSERT;
      end else if (r < ins_pct + del_pct) begin
         op = OP_DELETE;
         if (live_keys.size() != 0 && $urandom_range(0, 99) < 80)
            key = live_keys[$urandom_range(0, live_keys.size() - 1)];
      end else if (r < ins_pct + del_pct + qry_pct) begin
         op = OP_QUERY;
      end else begin
         op = OP_UNUSED;
      end
      send_word(op, key, 1'b0, '0);
   endtask

   task automatic check_rsp(input logic [RSP_TDATA_BITS-1:0] word);
      rsp_type got;
      rsp_type want;
      got.result_value = word[RESULT_BITS-1:0];
      got.status = status_type'(word[RESULT_BITS +: STATUS_BITS]);
      words_checked++;
      if (pending_results.size() == 0) begin
         if (mismatches < 10)
            $display("%0t: result word with nothing outstanding: value %h status %0d",
                     $realtime, got.result_value, got.status);
         mismatches++;
         return;
      end
      want = pending_results.pop_front();
      if (got.result_value !== want.result_value || got.status !== want.status) begin
         if (mismatches < 10)
            $display("%0t: word %0d: expected value %h status %0d, got value %h status %0d",
                     $realtime, words_checked, want.result_value, want.status,
                     got.result_value, got.status);
         mismatches++;
      end
   endtask

   // result side: check, then decide ready for the next edge
   int stall_left = 0;
   bit squeeze_done = 1'b0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) check_rsp(rsp_tdata);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!squeeze_done && words_checked >= 150) begin
            // hold off long enough for the block to back up and stall its input
            squeeze_done = 1'b1;
            stall_left = SQUEEZE_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet_stretch && $urandom_range(0, 99) < 15) begin
            stall_left = idle_len() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_binary_trie_max_xor_multiset_top: done, errors");
      $finish;
   end

   initial begin
      int i;
      hits[NULL_NODE] = 0;
      hits[ROOT_NODE] = 0;
      child[NULL_NODE] = '{NULL_NODE, NULL_NODE};
      child[ROOT_NODE] = '{NULL_NODE, NULL_NODE};
      alloc_ptr = FIRST_FREE_NODE;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIR_ROWS[n])
         send_word(DIR_ROWS[n].op, DIR_ROWS[n].key, DIR_ROWS[n].fixed, DIR_ROWS[n].want);

      for (i = 0; i < RANDOM_WORDS; i++) begin
         quiet_stretch = (i >= 300 && i < 360);
         send_random(35, 25, 35);
      end
      quiet_stretch = 1'b0;

      for (i = 0; i < 40; i++) send_random(30, 30, 35);

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d inserts (%0d refused on a full pool), %0d deletes (%0d absent)",
               n_ins, n_full, n_del, n_absent);
      $display("plus %0d queries and %0d unused-opcode words; %0d nodes used, %0d checked",
               n_qry, n_unused, alloc_ptr, words_checked);
      if (mismatches == 0) begin
         $display("tb_binary_trie_max_xor_multiset_top: done, clean");
      end else begin
         $display("tb_binary_trie_max_xor_multiset_top: done, errors");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/bmx_pkg.sv
rtl/core/bmx_node_ram.sv
rtl/core/bmx_engine.sv
rtl/core/binary_trie_max_xor_multiset_top.sv
tb/tb_binary_trie_max_xor_multiset_top.sv
